FILE: rtl/bdq_pkg.sv
`timescale 1ns / 1ps

package bdq_pkg;

    // Store geometry.
    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    // Request codes carried in the kind field.
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_DELETE     = 3'd4,
        OP_SEARCH     = 3'd5
    } op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_SCAN,
        S_SHIFT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    push_front;
        logic    push_back;
        logic    rd_front;
        logic    rd_back;
        logic    pop_front;
        logic    pop_back;
        logic    scan_clear;
        logic    scan_step;
        logic    shift_write;
        logic    del_done;
        logic    res_load;
        logic    res_found;
        status_t res_status;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  kind;
        logic full;
        logic empty;
        logic cmp_valid;
        logic match;
        logic more;
    } dp_sts_t;

endpackage

FILE: rtl/bdq_ram.sv
`timescale 1ns / 1ps

module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/bdq_dp.sv
`timescale 1ns / 1ps

module bdq_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bdq_pkg::dp_cmd_t            cmd,
    input  logic [2:0]                  kind,
    input  logic signed [31:0]          operand_value,
    output bdq_pkg::dp_sts_t            sts,
    output logic signed [31:0]          popped_value,
    output logic                        found,
    output logic [1:0]                  status,
    output logic [bdq_pkg::CNT_W-1:0]   entry_count
);
    import bdq_pkg::*;

    // Maps a logical position to a ring slot; the sum stays below twice the capacity.
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] front,
                                                 input logic [CNT_W-1:0] logical);
        logic [CNT_W:0] sum;
        begin
            sum = (CNT_W+1)'(front) + (CNT_W+1)'(logical);
            if (sum >= (CNT_W+1)'(CAPACITY))
            begin
                sum = sum - (CNT_W+1)'(CAPACITY);
            end
            return sum[IDX_W-1:0];
        end
    endfunction

    op_t                kind_reg;
    logic [DATA_W-1:0]  operand_reg;
    logic [IDX_W-1:0]   front_reg;
    logic [IDX_W-1:0]   front_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   idx_next;
    logic               cmp_valid_reg;
    logic               cmp_valid_next;
    logic [DATA_W-1:0]  popped_reg;
    logic               found_reg;
    status_t            status_reg;
    logic [CNT_W-1:0]   entry_count_reg;

    logic [IDX_W-1:0]   front_dec;
    logic [IDX_W-1:0]   front_inc;
    logic               more;
    logic               ram_wr_en;
    logic [IDX_W-1:0]   ram_wr_addr;
    logic [DATA_W-1:0]  ram_wr_data;
    logic               ram_rd_en;
    logic [IDX_W-1:0]   ram_rd_addr;
    logic [DATA_W-1:0]  ram_rd_data;

    // Ring pointer neighbors.
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - IDX_W'(1);
    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + IDX_W'(1);
    assign more      = (idx_reg < count_reg);

    // Status toward the controller.
    always_comb
    begin
        sts           = '0;
        sts.kind      = kind_reg;
        sts.full      = (count_reg == CAP_CNT);
        sts.empty     = (count_reg == '0);
        sts.cmp_valid = cmp_valid_reg;
        sts.match     = cmp_valid_reg && (ram_rd_data == operand_reg);
        sts.more      = more;
    end

    // Memory port selection.
    always_comb
    begin
        ram_wr_en   = cmd.push_front || cmd.push_back || cmd.shift_write;
        ram_wr_data = cmd.shift_write ? ram_rd_data : operand_reg;
        if (cmd.push_front)
        begin
            ram_wr_addr = front_dec;
        end
        else if (cmd.push_back)
        begin
            ram_wr_addr = slot_of(front_reg, count_reg);
        end
        else
        begin
            ram_wr_addr = slot_of(front_reg, idx_reg - CNT_W'(2));
        end

        ram_rd_en = cmd.rd_front || cmd.rd_back || (cmd.scan_step && more);
        if (cmd.rd_front)
        begin
            ram_rd_addr = front_reg;
        end
        else if (cmd.rd_back)
        begin
            ram_rd_addr = slot_of(front_reg, count_reg - CNT_W'(1));
        end
        else
        begin
            ram_rd_addr = slot_of(front_reg, idx_reg);
        end
    end

    // Next values of pointer, count and scan position.
    always_comb
    begin
        front_next     = front_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        cmp_valid_next = cmp_valid_reg;
        if (cmd.push_front)
        begin
            front_next = front_dec;
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.push_back)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.pop_front)
        begin
            front_next = front_inc;
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.pop_back || cmd.del_done)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.scan_clear)
        begin
            idx_next       = '0;
            cmp_valid_next = 1'b0;
        end
        if (cmd.scan_step)
        begin
            cmp_valid_next = more;
            if (more)
            begin
                idx_next = idx_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    // Request and result words.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg    <= op_t'(kind);
            operand_reg <= operand_value;
        end
        if (cmd.res_load)
        begin
            popped_reg      <= (cmd.pop_front || cmd.pop_back) ? ram_rd_data : '0;
            found_reg       <= cmd.res_found;
            status_reg      <= cmd.res_status;
            entry_count_reg <= count_next;
        end
    end

    assign popped_value = popped_reg;
    assign found        = found_reg;
    assign status       = status_reg;
    assign entry_count  = entry_count_reg;

    bdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // The held count never exceeds the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    // A push is only issued when there is room.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push_front || cmd.push_back) |-> !sts.full)
        else $error("push issued on a full store");

    // A shift write always has read data from the previous cycle behind it.
    a_shift_data: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_write |-> cmp_valid_reg && $past(ram_rd_en))
        else $error("shift write without fresh read data");

endmodule

FILE: rtl/bdq_ctrl.sv
`timescale 1ns / 1ps

module bdq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    input  bdq_pkg::dp_sts_t  sts,
    output bdq_pkg::dp_cmd_t  cmd
);
    import bdq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   out_free;

    // The result register can take a new word when it is empty or being drained.
    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Sequencer: next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // Wait here until the result register is free; nothing later stalls.
                if (out_free)
                begin
                    unique case (sts.kind) inside
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            cmd.res_load = 1'b1;
                            if (sts.full)
                            begin
                                cmd.res_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.push_front = (sts.kind == OP_PUSH_FRONT);
                                cmd.push_back  = (sts.kind == OP_PUSH_BACK);
                            end
                            state_next = S_IDLE;
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            if (sts.empty)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = ST_EMPTY;
                                state_next     = S_IDLE;
                            end
                            else
                            begin
                                cmd.rd_front = (sts.kind == OP_POP_FRONT);
                                cmd.rd_back  = (sts.kind == OP_POP_BACK);
                                state_next   = S_POP;
                            end
                        end
                        OP_DELETE, OP_SEARCH:
                        begin
                            cmd.scan_clear = 1'b1;
                            state_next     = S_SCAN;
                        end
                        default:
                        begin
                            cmd.res_load = 1'b1;
                            state_next   = S_IDLE;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                cmd.pop_front = (sts.kind == OP_POP_FRONT);
                cmd.pop_back  = (sts.kind == OP_POP_BACK);
                cmd.res_load  = 1'b1;
                state_next    = S_IDLE;
            end
            S_SCAN:
            begin
                // Reads are issued one per cycle; each compare sees the previous read.
                if (sts.match)
                begin
                    if (sts.kind == OP_SEARCH)
                    begin
                        cmd.res_load  = 1'b1;
                        cmd.res_found = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        cmd.scan_step = 1'b1;
                        state_next    = S_SHIFT;
                    end
                end
                else if (sts.cmp_valid || sts.more)
                begin
                    cmd.scan_step = 1'b1;
                end
                else
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SHIFT:
            begin
                // Each entry behind the match moves one place toward the front.
                if (sts.cmp_valid)
                begin
                    cmd.shift_write = 1'b1;
                    cmd.scan_step   = 1'b1;
                end
                else
                begin
                    cmd.del_done  = 1'b1;
                    cmd.res_load  = 1'b1;
                    cmd.res_found = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result valid flag.
    always_comb
    begin
        if (cmd.res_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    // A result is only written when the previous one has gone or is going.
    a_res_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> out_free)
        else $error("result overwritten while stalled");

    // A result appears only when the sequencer finished a request.
    a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(cmd.res_load))
        else $error("result valid without a finished request");

endmodule

FILE: rtl/bounded_deque_with_search_delete_unit.sv
`timescale 1ns / 1ps

// Bounded deque of signed 32-bit values with search and delete-first-match.
// Request channel: cmd_valid / cmd_stall carry one word of kind and operand_value.
// A word is taken when cmd_valid is high and cmd_stall is low. The unit works on one
// request at a time and holds cmd_stall high from the taking edge until it finishes.
// Result channel: rsp_valid / rsp_stall carry popped_value, found, status and
// entry_count, one result word per request.
// Order of work after the taking edge: pushes, error results and unused kinds write
// their result from the execute state, a pop reads the entry and then writes its
// result, and a search or a delete over N held entries walks them through the
// single read port of the entry memory, one entry per cycle in the scan and shift.
// A new request is taken on the cycle after a result is written.
// The result sits in an output register: while the receiver stalls, the unit still
// takes the next request but holds it, without touching the deque, until the
// result register drains.
// Reset clears the count and the front pointer, so the deque starts empty; the
// entry memory is not cleared, since only entries that were written are ever read.
module bounded_deque_with_search_delete_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_stall,
    input  logic [2:0]                  kind,
    input  logic signed [31:0]          operand_value,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output logic signed [31:0]          popped_value,
    output logic                        found,
    output logic [1:0]                  status,
    output logic [bdq_pkg::CNT_W-1:0]   entry_count
);
    import bdq_pkg::*;

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    // Sequencer.
    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (dp_sts),
        .cmd       (dp_cmd)
    );

    // Storage, pointers and result register.
    bdq_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (dp_cmd),
        .kind          (kind),
        .operand_value (operand_value),
        .sts           (dp_sts),
        .popped_value  (popped_value),
        .found         (found),
        .status        (status),
        .entry_count   (entry_count)
    );

endmodule
